@@ src/pt8_pkg.sv @@
// Shared types and constants of the prescaled 8-bit timer pair.
`default_nettype none
package pt8_pkg;

    // Prescaler size and clock tap positions
    localparam int PRESCALE_BITS = 15;
    localparam int TAP0_BIT      = 6;
    localparam int TAP1_BIT      = 8;
    localparam int TAP2_BIT      = 10;
    localparam int TAP3_BIT      = 14;

    // Tick count of one transaction saturates at the smaller of these
    localparam int MAX_TICKS  = 8;
    localparam int RESULT_CAP = 8;
    localparam int TICK_CAP   = (MAX_TICKS < RESULT_CAP) ? MAX_TICKS : RESULT_CAP;
    localparam int CNT_W      = $clog2(TICK_CAP + 1);
    localparam int TICKS_W    = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_LOW_CMP  = 2'd1;
    localparam logic [1:0] CFG_HIGH_CMP = 2'd2;
    localparam logic [1:0] CFG_BUF_CMP  = 2'd3;

    // Low clock select codes
    localparam logic [1:0] LSEL_PIN = 2'd0;
    localparam logic [1:0] LSEL_T0  = 2'd1;
    localparam logic [1:0] LSEL_T1  = 2'd2;
    localparam logic [1:0] LSEL_T2  = 2'd3;

    // High clock select codes
    localparam logic [1:0] HSEL_LOW_MATCH = 2'd0;
    localparam logic [1:0] HSEL_T0        = 2'd1;
    localparam logic [1:0] HSEL_T2        = 2'd2;
    localparam logic [1:0] HSEL_T3        = 2'd3;

    // Pair modes
    localparam logic [1:0] PM_TWO_TIMER = 2'd0;
    localparam logic [1:0] PM_CASCADE   = 2'd1;
    localparam logic [1:0] PM_PPG       = 2'd2;
    localparam logic [1:0] PM_PWM       = 2'd3;

    // PWM widths (any other code counts 8 bits)
    localparam logic [1:0] PWM_6BIT = 2'd1;
    localparam logic [1:0] PWM_7BIT = 2'd2;

    // Mode control register, bit 0 last
    typedef struct packed {
        logic       buf_en;
        logic       flop_sel;
        logic       flop_en;
        logic       high_en;
        logic       low_en;
        logic [1:0] pwm_width;
        logic [1:0] pair_mode;
        logic [1:0] high_sel;
        logic [1:0] low_sel;
        logic       run;
    } mode_t;

    // Timer state worked on by the shared counter unit
    typedef struct packed {
        logic [7:0] low_cnt;
        logic [7:0] high_cnt;
        logic [7:0] low_cmp;
        logic       low_irq;
        logic       high_irq;
        logic       flop;
    } tmr_t;

    typedef enum logic [0:0] {
        OP_LOW_PATH,
        OP_HIGH
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_LOW,
        ST_HIGH,
        ST_OUT
    } seq_state_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic in_ready;
        logic tick_step;
        logic low_step;
        logic high_step;
        logic out_valid;
        logic out_last;
    } ctrl_t;

endpackage
`default_nettype wire

@@ src/prescaled_8bit_timer_pair.sv @@
// Top level of the prescaled 8-bit timer pair: registers, tap decode, config port.
//
//  Channel  Direction  Handshake                     Payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata: ticks, line_level; tuser: req_type
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata: irqs, flop, counts; tlast: last
//  cfg      in         cfg_valid/cfg_ready           cfg_index, cfg_wdata
//
// A tick transaction of n ticks (saturated at eight) takes each tick through
// prescaler advance, low-path event, high event and result, the two events
// sharing one counter unit. A pin sample skips the advance, and a zero-tick
// transaction gives no result. Output stalls hold the sequencer in the result step.
// Configuration writes are taken only while the sequencer is idle.
// aresetn is synchronous and clears all state and configuration.
`default_nettype none
module prescaled_8bit_timer_pair (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [3:0] ticks, [4] line_level, [7:5] zero
    input  wire logic        s_axis_tuser,   // [0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [0] low_irq, [1] high_irq, [2] flop_out,
                                             // [3] flop_edge, [11:4] low_count,
                                             // [19:12] high_count, [23:20] zero
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_wdata
);

    pt8_pkg::ctrl_t  ctl;
    pt8_pkg::mode_t  mode_reg;
    pt8_pkg::tmr_t   tmr_reg;
    pt8_pkg::tmr_t   tmr_next;
    pt8_pkg::alu_op_t alu_op;

    logic [7:0]                      high_cmp_reg;
    logic [7:0]                      buf_cmp_reg;
    logic [pt8_pkg::PRESCALE_BITS-1:0] presc_reg;
    logic [pt8_pkg::PRESCALE_BITS-1:0] presc_next;
    logic                            toggled_reg;
    logic                            low_pend_reg;
    logic                            high_pend_reg;
    logic                            alu_toggle;
    logic                            alu_chain;
    logic                            in_accept;
    logic                            cfg_accept;
    logic                            fall0;
    logic                            fall1;
    logic                            fall2;
    logic                            fall3;
    logic                            low_ev;
    logic                            high_ev;
    logic                            high_taps_on;

    pt8_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .req_type (s_axis_tuser),
        .ticks    (s_axis_tdata[3:0]),
        .m_ready  (m_axis_tready),
        .ctl      (ctl)
    );

    // The high step reuses the same unit as the low step
    assign alu_op = ctl.high_step ? pt8_pkg::OP_HIGH : pt8_pkg::OP_LOW_PATH;

    pt8_alu u_alu (
        .op       (alu_op),
        .mode     (mode_reg),
        .high_cmp (high_cmp_reg),
        .buf_cmp  (buf_cmp_reg),
        .cur      (tmr_reg),
        .nxt      (tmr_next),
        .toggle   (alu_toggle),
        .chain    (alu_chain)
    );

    assign in_accept  = s_axis_tvalid && ctl.in_ready;
    assign cfg_accept = cfg_valid && cfg_ready;
    // hold off register writes while a transaction is being worked on
    assign cfg_ready  = ctl.in_ready;

    // Falling edges of the prescaler taps on this oscillator tick
    assign presc_next = presc_reg + pt8_pkg::PRESCALE_BITS'(1);
    assign fall0 = presc_reg[pt8_pkg::TAP0_BIT] && !presc_next[pt8_pkg::TAP0_BIT];
    assign fall1 = presc_reg[pt8_pkg::TAP1_BIT] && !presc_next[pt8_pkg::TAP1_BIT];
    assign fall2 = presc_reg[pt8_pkg::TAP2_BIT] && !presc_next[pt8_pkg::TAP2_BIT];
    assign fall3 = presc_reg[pt8_pkg::TAP3_BIT] && !presc_next[pt8_pkg::TAP3_BIT];

    assign low_ev = ((mode_reg.low_sel == pt8_pkg::LSEL_T0) && fall0)
                 || ((mode_reg.low_sel == pt8_pkg::LSEL_T1) && fall1)
                 || ((mode_reg.low_sel == pt8_pkg::LSEL_T2) && fall2);

    // High taps only clock the high counter in two-timer and PWM modes
    assign high_taps_on = (mode_reg.pair_mode == pt8_pkg::PM_TWO_TIMER)
                       || (mode_reg.pair_mode == pt8_pkg::PM_PWM);
    assign high_ev = high_taps_on
                  && (((mode_reg.high_sel == pt8_pkg::HSEL_T0) && fall0)
                   || ((mode_reg.high_sel == pt8_pkg::HSEL_T2) && fall2)
                   || ((mode_reg.high_sel == pt8_pkg::HSEL_T3) && fall3));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= '0;
            high_cmp_reg  <= '0;
            buf_cmp_reg   <= '0;
            presc_reg     <= '0;
            tmr_reg       <= '0;
            toggled_reg   <= 1'b0;
            low_pend_reg  <= 1'b0;
            high_pend_reg <= 1'b0;
        end else begin
            // pin sample: one low-path clock when the pin is high and selected
            if (in_accept && s_axis_tuser) begin
                toggled_reg   <= 1'b0;
                low_pend_reg  <= s_axis_tdata[4] && (mode_reg.low_sel == pt8_pkg::LSEL_PIN);
                high_pend_reg <= 1'b0;
            end
            // advance the prescaler and latch this tick's events
            if (ctl.tick_step) begin
                toggled_reg <= 1'b0;
                if (mode_reg.run) begin
                    presc_reg     <= presc_next;
                    low_pend_reg  <= low_ev;
                    high_pend_reg <= high_ev;
                end else begin
                    low_pend_reg  <= 1'b0;
                    high_pend_reg <= 1'b0;
                end
            end
            // low-path event; a low match may chain into the high counter
            if (ctl.low_step && low_pend_reg) begin
                tmr_reg       <= tmr_next;
                toggled_reg   <= toggled_reg || alu_toggle;
                high_pend_reg <= high_pend_reg || alu_chain;
            end
            if (ctl.high_step && high_pend_reg) begin
                tmr_reg     <= tmr_next;
                toggled_reg <= toggled_reg || alu_toggle;
            end
            // configuration writes are only taken while idle
            if (cfg_accept) begin
                case (cfg_index)
                    pt8_pkg::CFG_MODE: begin
                        mode_reg <= pt8_pkg::mode_t'(cfg_wdata);
                        if (!cfg_wdata[9]) begin
                            tmr_reg.low_cnt <= 8'd0;
                            tmr_reg.low_irq <= 1'b0;
                        end
                        if (!cfg_wdata[10]) begin
                            tmr_reg.high_cnt <= 8'd0;
                            tmr_reg.high_irq <= 1'b0;
                        end
                    end
                    pt8_pkg::CFG_LOW_CMP:  tmr_reg.low_cmp <= cfg_wdata[7:0];
                    pt8_pkg::CFG_HIGH_CMP: high_cmp_reg    <= cfg_wdata[7:0];
                    pt8_pkg::CFG_BUF_CMP:  buf_cmp_reg     <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // State is still during the result step, so drive the result from it
    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tvalid = ctl.out_valid;
    assign m_axis_tlast  = ctl.out_last;
    assign m_axis_tdata  = {4'd0, tmr_reg.high_cnt, tmr_reg.low_cnt, toggled_reg,
                            tmr_reg.flop, tmr_reg.high_irq, tmr_reg.low_irq};

endmodule
`default_nettype wire

@@ src/pt8_alu.sv @@
// Shared counter unit: one low-path or high-counter clock event.
`default_nettype none
module pt8_alu (
    input  var pt8_pkg::alu_op_t op,
    input  var pt8_pkg::mode_t   mode,
    input  wire logic [7:0]      high_cmp,
    input  wire logic [7:0]      buf_cmp,
    input  var pt8_pkg::tmr_t    cur,
    output pt8_pkg::tmr_t        nxt,
    output logic                 toggle,
    output logic                 chain
);

    logic [7:0] operand;
    logic [7:0] sum;
    logic [7:0] pwm_sum;
    logic [7:0] high_sum;
    logic [7:0] casc_high;
    logic       low_eq;
    logic       high_eq;
    logic       ppg_eqh;
    logic       casc_eq;
    logic       pwm_eq;
    logic       pwm_pulse;

    assign operand   = (op == pt8_pkg::OP_HIGH) ? cur.high_cnt : cur.low_cnt;
    assign sum       = operand + 8'd1;
    assign high_sum  = cur.high_cnt + 8'd1;
    assign casc_high = (sum == 8'd0) ? high_sum : cur.high_cnt;

    always_comb begin
        case (mode.pwm_width)
            pt8_pkg::PWM_6BIT: pwm_sum = {2'b00, sum[5:0]};
            pt8_pkg::PWM_7BIT: pwm_sum = {1'b0, sum[6:0]};
            default:           pwm_sum = sum;
        endcase
    end

    assign low_eq    = (sum == cur.low_cmp);
    assign high_eq   = (sum == high_cmp);
    assign ppg_eqh   = (sum == high_cmp);
    assign casc_eq   = low_eq && (casc_high == high_cmp);
    assign pwm_eq    = (pwm_sum == cur.low_cmp);
    assign pwm_pulse = (pwm_sum == 8'd0);

    always_comb begin
        nxt    = cur;
        toggle = 1'b0;
        chain  = 1'b0;
        case (op)
            pt8_pkg::OP_HIGH: begin
                if (mode.high_en) begin
                    nxt.high_irq = high_eq;
                    nxt.high_cnt = high_eq ? 8'd0 : sum;
                    toggle       = high_eq && mode.flop_en && mode.flop_sel;
                end
            end
            default: begin
                case (mode.pair_mode)
                    pt8_pkg::PM_TWO_TIMER: begin
                        if (mode.low_en) begin
                            nxt.low_irq = low_eq;
                            nxt.low_cnt = low_eq ? 8'd0 : sum;
                            toggle      = low_eq && mode.flop_en && !mode.flop_sel;
                            chain       = low_eq && (mode.high_sel == pt8_pkg::HSEL_LOW_MATCH);
                        end
                    end
                    pt8_pkg::PM_CASCADE: begin
                        if (mode.low_en && mode.high_en) begin
                            nxt.high_irq = casc_eq;
                            nxt.low_cnt  = casc_eq ? 8'd0 : sum;
                            nxt.high_cnt = casc_eq ? 8'd0 : casc_high;
                            toggle       = casc_eq && mode.flop_en;
                        end
                    end
                    pt8_pkg::PM_PPG: begin
                        if (mode.low_en) begin
                            nxt.low_irq  = low_eq;
                            nxt.high_irq = ppg_eqh;
                            nxt.low_cnt  = ppg_eqh ? 8'd0 : sum;
                            toggle       = (low_eq || ppg_eqh) && mode.flop_en;
                            if (ppg_eqh && mode.buf_en) begin
                                nxt.low_cmp = buf_cmp;
                            end
                        end
                    end
                    default: begin
                        if (mode.low_en) begin
                            nxt.low_irq = pwm_eq || pwm_pulse;
                            nxt.low_cnt = pwm_sum;
                            toggle      = (pwm_eq || pwm_pulse) && mode.flop_en;
                            if (pwm_pulse && mode.buf_en) begin
                                nxt.low_cmp = buf_cmp;
                            end
                        end
                    end
                endcase
            end
        endcase
        nxt.flop = cur.flop ^ toggle;
    end

endmodule
`default_nettype wire

@@ src/pt8_ctrl.sv @@
// Sequencer: walks each tick through advance, low event, high event and result.
`default_nettype none
module pt8_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        req_type,
    input  wire logic [pt8_pkg::TICKS_W-1:0] ticks,
    input  wire logic                        m_ready,
    output pt8_pkg::ctrl_t                   ctl
);

    pt8_pkg::seq_state_t       state_reg;
    pt8_pkg::seq_state_t       state_next;
    logic [pt8_pkg::CNT_W-1:0] left_reg;
    logic [pt8_pkg::CNT_W-1:0] left_next;
    logic [pt8_pkg::CNT_W-1:0] sat_ticks;

    // saturate the requested tick count
    assign sat_ticks = (ticks > pt8_pkg::TICKS_W'(pt8_pkg::TICK_CAP))
                     ? pt8_pkg::CNT_W'(pt8_pkg::TICK_CAP)
                     : pt8_pkg::CNT_W'(ticks);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pt8_pkg::ST_IDLE;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        left_next  = left_reg;
        case (state_reg)
            pt8_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (req_type) begin
                        left_next  = pt8_pkg::CNT_W'(1);
                        state_next = pt8_pkg::ST_LOW;
                    end else if (sat_ticks != '0) begin
                        left_next  = sat_ticks;
                        state_next = pt8_pkg::ST_TICK;
                    end
                end
            end
            pt8_pkg::ST_TICK: state_next = pt8_pkg::ST_LOW;
            pt8_pkg::ST_LOW:  state_next = pt8_pkg::ST_HIGH;
            pt8_pkg::ST_HIGH: state_next = pt8_pkg::ST_OUT;
            pt8_pkg::ST_OUT: begin
                if (m_ready) begin
                    left_next  = left_reg - pt8_pkg::CNT_W'(1);
                    state_next = (left_reg == pt8_pkg::CNT_W'(1))
                               ? pt8_pkg::ST_IDLE : pt8_pkg::ST_TICK;
                end
            end
            default: state_next = pt8_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl = '0;
        case (state_reg)
            pt8_pkg::ST_IDLE: ctl.in_ready  = 1'b1;
            pt8_pkg::ST_TICK: ctl.tick_step = 1'b1;
            pt8_pkg::ST_LOW:  ctl.low_step  = 1'b1;
            pt8_pkg::ST_HIGH: ctl.high_step = 1'b1;
            pt8_pkg::ST_OUT: begin
                ctl.out_valid = 1'b1;
                ctl.out_last  = (left_reg == pt8_pkg::CNT_W'(1));
            end
            default: ctl = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/pt8_checker.sv @@
// Port-level checks of the prescaled 8-bit timer pair, bound to the top level.
`default_nettype none
module pt8_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        cfg_valid
);

    // one transaction at a time: never take input while a result is shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    // a working transaction blocks the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tdata[3:0] != 4'd0))
        |=> !s_axis_tready)
        else $error("input ready straight after a working transaction");

    // a pin sample yields its single, final result after the low and high steps
    a_pin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |-> ##3 (m_axis_tvalid && m_axis_tlast))
        else $error("pin sample result missing or not last");

    // more results follow a result that is not last
    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
        else $error("input ready before the last result");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready && !cfg_valid)
        |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind prescaled_8bit_timer_pair pt8_checker u_pt8_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid)
);
`default_nettype wire

@@ verif/tb_prescaled_8bit_timer_pair.sv @@
// Self-checking testbench for the prescaled 8-bit timer pair: stream stimulus, own timer model.
module tb_prescaled_8bit_timer_pair;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_MAX        = 11;   // longest random gap on either side
    localparam int RX_HOLD_CYCLES  = 150;  // long receiver hold-off
    localparam int SETTLE_CYCLES   = 8;    // quiet cycles after the last owed result
    localparam int END_CYCLES      = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 17;
    localparam int PWM_SWEEP_ITEMS = 100;

    // One result transaction, first field in the top bit
    typedef struct packed {
        logic       low_irq;
        logic       high_irq;
        logic       flop_out;
        logic       flop_edge;
        logic [7:0] low_count;
        logic [7:0] high_count;
        logic       last;
    } timer_reading_t;

    // Timer pair model plus the queue of readings still owed by the block
    class timer_pair_scoreboard;
        pt8_pkg::mode_t                    mode         = '0;
        logic [7:0]                        high_cmp_reg = '0;
        logic [7:0]                        buf_cmp_reg  = '0;
        logic [pt8_pkg::PRESCALE_BITS-1:0] prescaler    = '0;
        logic [7:0]                        low_cnt      = '0;
        logic [7:0]                        high_cnt     = '0;
        logic [7:0]                        low_cmp      = '0;
        logic                              low_irq      = 1'b0;
        logic                              high_irq     = 1'b0;
        logic                              flop         = 1'b0;
        logic                              flop_moved   = 1'b0;
        timer_reading_t                    due_readings[$];
        int                                errors       = 0;

        function void write_reg(logic [1:0] index, logic [13:0] value);
            case (index)
                pt8_pkg::CFG_MODE: begin
                    mode = pt8_pkg::mode_t'(value);
                    // a disabled counter drops its count and its interrupt
                    if (!mode.low_en) begin
                        low_cnt = '0;
                        low_irq = 1'b0;
                    end
                    if (!mode.high_en) begin
                        high_cnt = '0;
                        high_irq = 1'b0;
                    end
                end
                pt8_pkg::CFG_LOW_CMP:  low_cmp      = value[7:0];
                pt8_pkg::CFG_HIGH_CMP: high_cmp_reg = value[7:0];
                default:               buf_cmp_reg  = value[7:0];
            endcase
        endfunction

        function void toggle_flop();
            flop       = !flop;
            flop_moved = 1'b1;
        endfunction

        function void bump_high_counter();
            if (!mode.high_en) return;
            high_cnt = high_cnt + 8'd1;
            high_irq = (high_cnt == high_cmp_reg);
            if (high_irq) begin
                if (mode.flop_en && mode.flop_sel) toggle_flop();
                high_cnt = '0;
            end
        endfunction

        function void drive_low_path();
            logic hit_low;
            logic hit_high;
            logic wrapped;
            case (mode.pair_mode)
                pt8_pkg::PM_TWO_TIMER: begin
                    if (!mode.low_en) return;
                    low_cnt = low_cnt + 8'd1;
                    low_irq = (low_cnt == low_cmp);
                    if (low_irq) begin
                        if (mode.flop_en && !mode.flop_sel) toggle_flop();
                        if (mode.high_sel == pt8_pkg::HSEL_LOW_MATCH) bump_high_counter();
                        low_cnt = '0;
                    end
                end
                pt8_pkg::PM_CASCADE: begin
                    if (!mode.low_en || !mode.high_en) return;
                    low_cnt = low_cnt + 8'd1;
                    if (low_cnt == 8'd0) high_cnt = high_cnt + 8'd1;
                    high_irq = (low_cnt == low_cmp) && (high_cnt == high_cmp_reg);
                    if (high_irq) begin
                        if (mode.flop_en) toggle_flop();
                        low_cnt  = '0;
                        high_cnt = '0;
                    end
                end
                pt8_pkg::PM_PPG: begin
                    if (!mode.low_en) return;
                    low_cnt  = low_cnt + 8'd1;
                    hit_low  = (low_cnt == low_cmp);
                    hit_high = (low_cnt == high_cmp_reg);
                    low_irq  = hit_low;
                    high_irq = hit_high;
                    // both matches together still flip only once
                    if ((hit_low || hit_high) && mode.flop_en) toggle_flop();
                    if (hit_high) begin
                        if (mode.buf_en) low_cmp = buf_cmp_reg;
                        low_cnt = '0;
                    end
                end
                default: begin
                    if (!mode.low_en) return;
                    low_cnt = low_cnt + 8'd1;
                    if (mode.pwm_width == pt8_pkg::PWM_6BIT) low_cnt[7:6] = 2'b00;
                    if (mode.pwm_width == pt8_pkg::PWM_7BIT) low_cnt[7] = 1'b0;
                    wrapped = (low_cnt == 8'd0);
                    low_irq = (low_cnt == low_cmp) || wrapped;
                    if (low_irq && mode.flop_en) toggle_flop();
                    if (wrapped && mode.buf_en) low_cmp = buf_cmp_reg;
                end
            endcase
        endfunction

        function void feed_high_tap(logic [1:0] tap);
            if (mode.high_sel == tap &&
                (mode.pair_mode == pt8_pkg::PM_TWO_TIMER || mode.pair_mode == pt8_pkg::PM_PWM))
                bump_high_counter();
        endfunction

        function void queue_reading(logic last);
            timer_reading_t r;
            r = {low_irq, high_irq, flop, flop_moved, low_cnt, high_cnt, last};
            due_readings.push_back(r);
        endfunction

        // Advance the model by one accepted input transaction
        function void note_input(logic pin_req, logic [3:0] ticks, logic pin_level);
            int                                n;
            logic [pt8_pkg::PRESCALE_BITS-1:0] was;
            logic [pt8_pkg::PRESCALE_BITS-1:0] fallen;
            if (pin_req) begin
                flop_moved = 1'b0;
                if (pin_level && mode.low_sel == pt8_pkg::LSEL_PIN) drive_low_path();
                queue_reading(1'b1);
                return;
            end
            n = (ticks > pt8_pkg::TICK_CAP) ? pt8_pkg::TICK_CAP : int'(ticks);
            for (int k = 0; k < n; k++) begin
                flop_moved = 1'b0;
                if (mode.run) begin
                    was       = prescaler;
                    prescaler = prescaler + 1'b1;
                    fallen    = was & ~prescaler;
                    if (fallen[pt8_pkg::TAP0_BIT]) begin
                        if (mode.low_sel == pt8_pkg::LSEL_T0) drive_low_path();
                        feed_high_tap(pt8_pkg::HSEL_T0);
                    end
                    if (fallen[pt8_pkg::TAP1_BIT] && mode.low_sel == pt8_pkg::LSEL_T1)
                        drive_low_path();
                    if (fallen[pt8_pkg::TAP2_BIT]) begin
                        if (mode.low_sel == pt8_pkg::LSEL_T2) drive_low_path();
                        feed_high_tap(pt8_pkg::HSEL_T2);
                    end
                    if (fallen[pt8_pkg::TAP3_BIT]) feed_high_tap(pt8_pkg::HSEL_T3);
                end
                queue_reading(k == n - 1);
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] data, logic last_flag);
            timer_reading_t want;
            if (due_readings.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %h last %b",
                         $time, data, last_flag);
                errors++;
                return;
            end
            want = due_readings.pop_front();
            check_field("low_irq",    8'(want.low_irq),   8'(data[0]));
            check_field("high_irq",   8'(want.high_irq),  8'(data[1]));
            check_field("flop_out",   8'(want.flop_out),  8'(data[2]));
            check_field("flop_edge",  8'(want.flop_edge), 8'(data[3]));
            check_field("low_count",  want.low_count,     data[11:4]);
            check_field("high_count", want.high_count,    data[19:12]);
            check_field("last",       8'(want.last),      8'(last_flag));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [3:0] ticks, [4] line_level, [7:5] zero
    logic        s_axis_tuser;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [0] low_irq, [1] high_irq, [2] flop_out, [3] flop_edge,
                                 // [11:4] low_count, [19:12] high_count, [23:20] zero
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_wdata;

    // Idling switches of the sender and the result sink
    bit tx_idling   = 1'b1;
    bit rx_idling   = 1'b1;
    bit rx_hold_req = 1'b0;

    timer_pair_scoreboard board;

    prescaled_8bit_timer_pair dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Offer one input transaction and hold it until the block takes it.
    // Valid stays high afterwards so back-to-back transactions never drop it.
    task automatic send_item(input logic pin_req, input logic [3:0] ticks,
                             input logic pin_level);
        int gap;
        gap = tx_idling ? $urandom_range(IDLE_MAX, 0) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, pin_level, ticks};
        s_axis_tuser  <= pin_req;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_input(pin_req, ticks, pin_level);
    endtask

    // Stop offering input and wait until every owed result has come back,
    // then idle before the next step
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.due_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers back to back; only call with the block idle
    task automatic configure(input pt8_pkg::mode_t mode_word, input logic [7:0] low_v,
                             input logic [7:0] high_v, input logic [7:0] buffer_v);
        logic [1:0]  regs  [4];
        logic [13:0] words [4];
        regs  = '{pt8_pkg::CFG_MODE, pt8_pkg::CFG_LOW_CMP, pt8_pkg::CFG_HIGH_CMP,
                  pt8_pkg::CFG_BUF_CMP};
        words = '{mode_word, 14'(low_v), 14'(high_v), 14'(buffer_v)};
        foreach (regs[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= words[i];
            do @(posedge aclk); while (!cfg_ready);
            board.write_reg(regs[i], words[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Compare values: all zero in the first random phase, all ones in the
    // last, otherwise mostly small so that matches come often
    function automatic logic [7:0] pick_compare(int phase);
        if (phase == 0) return 8'd0;
        if (phase == RANDOM_PHASES - 1) return 8'hFF;
        if ($urandom_range(4, 0) == 0) return 8'($urandom_range(255, 0));
        return 8'($urandom_range(6, 1));
    endfunction

    // Result sink: random stall after each result while rx_idling is set, plus one long
    // hold-off on request, counted here so the sender keeps pushing meanwhile
    initial begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata, m_axis_tlast);
                stall = rx_idling ? $urandom_range(IDLE_MAX, 0) : 0;
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall       = RX_HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        pt8_pkg::mode_t m;
        int             pick;
        int             sweep_items;

        board = new();
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= pt8_pkg::CFG_MODE;
        cfg_wdata     <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: two timers clocked from the pin, low match feeds the high
        // counter; zero ticks, saturated tick counts and pin samples
        m           = '0;
        m.run       = 1'b1;
        m.low_sel   = pt8_pkg::LSEL_PIN;
        m.high_sel  = pt8_pkg::HSEL_LOW_MATCH;
        m.pair_mode = pt8_pkg::PM_TWO_TIMER;
        m.low_en    = 1'b1;
        m.high_en   = 1'b1;
        m.flop_en   = 1'b1;
        configure(m, 8'd2, 8'd2, 8'd0);
        send_item(1'b0, 4'd0,  1'b0);
        send_item(1'b0, 4'd15, 1'b1);
        send_item(1'b0, 4'd9,  1'b0);
        send_item(1'b0, 4'd1,  1'b1);
        send_item(1'b1, 4'd0,  1'b1);
        send_item(1'b1, 4'd15, 1'b1);
        send_item(1'b1, 4'hA,  1'b1);
        send_item(1'b1, 4'd5,  1'b1);
        send_item(1'b1, 4'd0,  1'b0);
        drain_results();

        // Directed: stopped prescaler in PPG; ticks change nothing, the pin
        // still clocks; equal compares flip once and reload from the buffer
        m.run       = 1'b0;
        m.pair_mode = pt8_pkg::PM_PPG;
        m.buf_en    = 1'b1;
        configure(m, 8'd1, 8'd1, 8'd3);
        send_item(1'b0, 4'd8, 1'b0);
        send_item(1'b0, 4'd3, 1'b1);
        repeat (4) send_item(1'b1, 4'd0, 1'b1);
        drain_results();

        // Directed: both counters disabled in PWM, which clears them
        m           = '0;
        m.run       = 1'b1;
        m.low_sel   = pt8_pkg::LSEL_PIN;
        m.pair_mode = pt8_pkg::PM_PWM;
        m.pwm_width = pt8_pkg::PWM_7BIT;
        configure(m, 8'd5, 8'd7, 8'd9);
        send_item(1'b1, 4'd0, 1'b1);
        send_item(1'b1, 4'd0, 1'b1);
        send_item(1'b0, 4'd2, 1'b0);
        drain_results();

        // Prescaler sweep with no idling. First 6-bit PWM with low and high both
        // on T0 and flop_sel set, so the low path and the high match can flip it twice.
        tx_idling   = 1'b0;
        rx_idling   = 1'b0;
        m           = '0;
        m.run       = 1'b1;
        m.low_sel   = pt8_pkg::LSEL_T0;
        m.high_sel  = pt8_pkg::HSEL_T0;
        m.pair_mode = pt8_pkg::PM_PWM;
        m.pwm_width = pt8_pkg::PWM_6BIT;
        m.low_en    = 1'b1;
        m.high_en   = 1'b1;
        m.flop_en   = 1'b1;
        m.flop_sel  = 1'b1;
        m.buf_en    = 1'b1;
        configure(m, 8'd1, 8'd1, 8'd1);
        repeat (PWM_SWEEP_ITEMS) send_item(1'b0, 4'd8, 1'b0);
        drain_results();

        // Then two timers, both on T2; run on until T2 has fallen once
        m.low_sel   = pt8_pkg::LSEL_T2;
        m.high_sel  = pt8_pkg::HSEL_T2;
        m.pair_mode = pt8_pkg::PM_TWO_TIMER;
        m.pwm_width = 2'b00;
        m.buf_en    = 1'b0;
        configure(m, 8'd3, 8'd1, 8'd0);
        sweep_items = ((1 << (pt8_pkg::TAP2_BIT + 1)) - int'(board.prescaler) + 7) / 8 + 1;
        repeat (sweep_items) send_item(1'b0, 4'd8, 1'b0);
        drain_results();

        // Random phases, each with its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(3, 0) == 0) begin
                m = pt8_pkg::mode_t'(14'($urandom_range(16383, 0)));
            end else begin
                m           = '0;
                m.run       = ($urandom_range(7, 0) != 0);
                m.low_sel   = $urandom_range(1, 0) ? pt8_pkg::LSEL_PIN
                                                   : 2'($urandom_range(3, 1));
                m.high_sel  = 2'($urandom_range(3, 0));
                m.pair_mode = 2'($urandom_range(3, 0));
                m.pwm_width = 2'($urandom_range(3, 0));
                m.low_en    = ($urandom_range(7, 0) != 0);
                m.high_en   = ($urandom_range(7, 0) != 0);
                m.flop_en   = ($urandom_range(3, 0) != 0);
                m.flop_sel  = 1'($urandom_range(1, 0));
                m.buf_en    = 1'($urandom_range(1, 0));
            end
            configure(m, pick_compare(phase), pick_compare(phase), pick_compare(phase));
            // leave some phases without gaps on one side or the other
            tx_idling = ($urandom_range(3, 0) != 0);
            rx_idling = ($urandom_range(3, 0) != 0);

            for (int j = 0; j < PHASE_ITEMS; j++) begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 2 && j == 5) begin
                    rx_hold_req = 1'b1;
                    tx_idling   = 1'b0;
                end
                // let everything owed arrive before going on
                if ((phase == 4 && j == 10) || $urandom_range(29, 0) == 0)
                    drain_results();
                pick = $urandom_range(99, 0);
                if (pick < 35)
                    send_item(1'b1, 4'($urandom_range(15, 0)),
                              ($urandom_range(3, 0) != 0));
                else if (pick < 94)
                    send_item(1'b0, 4'($urandom_range(8, 1)), 1'($urandom_range(1, 0)));
                else
                    send_item(1'b0, pick[0] ? 4'd0 : 4'($urandom_range(15, 9)),
                              1'($urandom_range(1, 0)));
            end
            drain_results();
        end

        repeat (END_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.due_readings.size() == 0) begin
            $display("prescaled_8bit_timer_pair test passed");
        end else begin
            $display("prescaled_8bit_timer_pair test failed");
        end
        $finish;
    end

    // Run limit, well beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("prescaled_8bit_timer_pair test failed");
        $finish;
    end

endmodule
